### rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define ASSERT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/pfsd_pkg.sv
// ----------------------------------------------------------------------------
// pfsd_pkg
// Types and constants of the palette error-diffusion dither core.
// ----------------------------------------------------------------------------
package pfsd_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int CACHE_BITS    = 6;
   localparam int PALETTE_DEPTH = 256;

   localparam int NCH      = 3;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ERR_AW   = COL_W + 1;
   localparam int CACHE_AW = 3 * CACHE_BITS;
   localparam int CLR_AW   = (CACHE_AW > ERR_AW) ? CACHE_AW : ERR_AW;
   localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
   localparam int ERR_W    = 13;   // one channel of stored error
   localparam int V_W      = 15;   // scaled pixel plus error
   localparam int D_W      = 10;   // quantization error
   localparam int SQ_W     = 16;
   localparam int ACC_W    = 21;

   // request types
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_PIXEL = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;

   // register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_SIZE = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] entry_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] entry_code;
   } pfsd_req_type;

   typedef struct packed {
      logic [7:0] out_pixel;
      logic       row_end;
      logic       image_end;
   } pfsd_rsp_type;

   // palette word: channel 0 red, 1 green, 2 blue
   typedef struct packed {
      logic [7:0]           code;
      logic [NCH-1:0][7:0]  color;
   } pfsd_pal_type;

   typedef logic [NCH-1:0][ERR_W-1:0] pfsd_err_type;

endpackage

### rtl/palette_floyd_steinberg_dither_core.sv
// ----------------------------------------------------------------------------
// palette_floyd_steinberg_dither_core
// Error-diffusion dither of an RGB stream to a loaded palette with a cache.
// ----------------------------------------------------------------------------
//   channel  direction  payload          handshake
//   req_     in         pfsd_req_type    req_valid / req_ready
//   rsp_     out        pfsd_rsp_type    rsp_valid / rsp_ready
//   csr_     in         index, data      csr_valid / csr_ready (always ready)
//
// Load, start and ignored beats are taken in idle. A pixel runs sum, cache
// lookup, palette read, error, a read and a write per downward error update
// (up to three) and emit; a cache miss adds a palette read, four squarer steps
// and a compare per entry searched, paced by the single squarer. After reset
// and each start beat, a clearing pass sweeps the cache and error rows one
// entry a cycle; req_ready stays low meanwhile. A finished result waits in the
// output register; the next pixel stalls only at emit while it is still held.
module palette_floyd_steinberg_dither_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  pfsd_pkg::pfsd_req_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output pfsd_pkg::pfsd_rsp_type                 rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pfsd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pfsd_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_SUM  = 4'd2;
   localparam logic [3:0] S_CRD  = 4'd3;
   localparam logic [3:0] S_CCHK = 4'd4;
   localparam logic [3:0] S_PRD  = 4'd5;
   localparam logic [3:0] S_D0   = 4'd6;
   localparam logic [3:0] S_D1   = 4'd7;
   localparam logic [3:0] S_D2   = 4'd8;
   localparam logic [3:0] S_D3   = 4'd9;
   localparam logic [3:0] S_CMP  = 4'd10;
   localparam logic [3:0] S_PAL  = 4'd11;
   localparam logic [3:0] S_ERR  = 4'd12;
   localparam logic [3:0] S_DRD  = 4'd13;
   localparam logic [3:0] S_DWR  = 4'd14;
   localparam logic [3:0] S_EMIT = 4'd15;

   localparam logic [1:0] T_LEFT   = 2'd0;
   localparam logic [1:0] T_CENTER = 2'd1;
   localparam logic [1:0] T_RIGHT  = 2'd2;

   localparam int COL_W  = pfsd_pkg::COL_W;
   localparam int PAL_AW = pfsd_pkg::PAL_AW;
   localparam int NCH    = pfsd_pkg::NCH;
   localparam int ERR_W  = pfsd_pkg::ERR_W;
   localparam int V_W    = pfsd_pkg::V_W;
   localparam int D_W    = pfsd_pkg::D_W;
   localparam int ACC_W  = pfsd_pkg::ACC_W;
   localparam int SQ_W   = pfsd_pkg::SQ_W;
   localparam int CB     = pfsd_pkg::CACHE_BITS;

   // memories
   pfsd_pkg::pfsd_pal_type  pal_mem   [pfsd_pkg::PALETTE_DEPTH];
   logic [PAL_AW:0]         cache_mem [2**pfsd_pkg::CACHE_AW];
   pfsd_pkg::pfsd_err_type  err_mem   [2**pfsd_pkg::ERR_AW];

   // control and datapath registers
   logic [3:0]                   state_ff, state_in;
   logic [pfsd_pkg::CLR_AW-1:0]  clr_ff, clr_in;
   logic [12:0]                  width_ff;
   logic [15:0]                  height_ff;
   logic [8:0]                   psize_ff;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [15:0]                  row_ff, row_in;
   logic                         sel_ff, sel_in;
   pfsd_pkg::pfsd_err_type       right_ff, right_in;
   logic [COL_W-1:0]             x_ff, x_in;
   logic                         lcol_ff, lcol_in;
   logic                         lrow_ff, lrow_in;
   logic [NCH-1:0][7:0]          pin_ff, pin_in;
   logic [NCH-1:0][7:0]          val_ff, val_in;
   logic [NCH-1:0][D_W-1:0]      dq_ff, dq_in;
   logic [PAL_AW-1:0]            idx_ff, idx_in;
   logic [PAL_AW-1:0]            best_ff, best_in;
   logic [ACC_W-1:0]             bestd_ff, bestd_in;
   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic [SQ_W-1:0]              sq_ff, sq_in;
   logic [PAL_AW-1:0]            ent_ff, ent_in;
   logic [7:0]                   code_ff, code_in;
   logic [1:0]                   tgt_ff, tgt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   pfsd_pkg::pfsd_rsp_type       rsp_data_ff, rsp_data_in;

   // memory read data
   pfsd_pkg::pfsd_pal_type       pal_rd_ff;
   logic [PAL_AW:0]              cache_rd_ff;
   pfsd_pkg::pfsd_err_type       err_rd_ff;

   // memory port controls
   logic                         pal_we;
   logic [PAL_AW-1:0]            pal_wa, pal_ra;
   logic                         cache_we;
   logic [pfsd_pkg::CACHE_AW-1:0] cache_wa, cache_ra;
   logic [PAL_AW:0]              cache_wd;
   logic                         err_we;
   logic [pfsd_pkg::ERR_AW-1:0]  err_wa, err_ra;
   pfsd_pkg::pfsd_err_type       err_wd;

   logic                         req_fire;
   logic [12:0]                  w_eff;
   logic [16:0]                  h_eff;
   logic [8:0]                   n_eff;
   logic [pfsd_pkg::CACHE_AW-1:0] key;
   logic [D_W-1:0]               diff;
   logic [7:0]                   mag;
   logic [ACC_W-1:0]             wsq;
   logic                         hit_zero, better, last_idx;
   logic [PAL_AW-1:0]            pick;
   logic                         right_ok;
   logic [COL_W-1:0]             tgt_x;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_fire  = req_valid && req_ready;

   // effective limits
   always_comb begin
      w_eff = width_ff;
      if (width_ff == 13'd0) begin
         w_eff = 13'd1;
      end else if (width_ff > 13'(pfsd_pkg::MAX_WIDTH)) begin
         w_eff = 13'(pfsd_pkg::MAX_WIDTH);
      end
      h_eff = (height_ff == 16'd0) ? 17'd1 : {1'b0, height_ff};
      n_eff = psize_ff;
      if (psize_ff == 9'd0) begin
         n_eff = 9'd1;
      end else if (psize_ff > 9'(pfsd_pkg::PALETTE_DEPTH)) begin
         n_eff = 9'(pfsd_pkg::PALETTE_DEPTH);
      end
   end

   // cache key from the top bits of each channel
   assign key = {val_ff[0][7 -: CB], val_ff[1][7 -: CB], val_ff[2][7 -: CB]};

   // shared squarer input: channel picked by the search step
   always_comb begin
      unique case (state_ff)
         S_D0:    diff = D_W'({2'b00, val_ff[0]}) - D_W'({2'b00, pal_rd_ff.color[0]});
         S_D1:    diff = D_W'({2'b00, val_ff[1]}) - D_W'({2'b00, pal_rd_ff.color[1]});
         S_D2:    diff = D_W'({2'b00, val_ff[2]}) - D_W'({2'b00, pal_rd_ff.color[2]});
         default: diff = '0;
      endcase
      mag   = diff[D_W-1] ? 8'(-diff) : diff[7:0];
      sq_in = mag * mag;
      // weights 11, 16, 5 by shift and add
      unique case (state_ff)
         S_D1:    wsq = ACC_W'({sq_ff, 3'b000}) + ACC_W'({sq_ff, 1'b0}) + ACC_W'(sq_ff);
         S_D2:    wsq = ACC_W'({sq_ff, 4'b0000});
         S_D3:    wsq = ACC_W'({sq_ff, 2'b00}) + ACC_W'(sq_ff);
         default: wsq = '0;
      endcase
   end

   // search compare
   assign hit_zero = (acc_ff == '0);
   assign better   = (idx_ff == '0) || (acc_ff < bestd_ff);
   assign last_idx = ((9'(idx_ff) + 9'd1) >= n_eff);
   assign pick     = (hit_zero || better) ? idx_ff : best_ff;

   assign right_ok = !lcol_ff && (x_ff != COL_W'(pfsd_pkg::MAX_WIDTH - 1));

   always_comb begin
      unique case (tgt_ff)
         T_LEFT:  tgt_x = x_ff - COL_W'(1);
         T_RIGHT: tgt_x = x_ff + COL_W'(1);
         default: tgt_x = x_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sel_in       = sel_ff;
      right_in     = right_ff;
      x_in         = x_ff;
      lcol_in      = lcol_ff;
      lrow_in      = lrow_ff;
      pin_in       = pin_ff;
      val_in       = val_ff;
      dq_in        = dq_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      bestd_in     = bestd_ff;
      acc_in       = acc_ff;
      ent_in       = ent_ff;
      code_in      = code_ff;
      tgt_in       = tgt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      pal_we   = 1'b0;
      pal_wa   = req_data.entry_index[PAL_AW-1:0];
      pal_ra   = (state_ff == S_PAL) ? ent_ff : idx_ff;
      cache_we = 1'b0;
      cache_wa = key;
      cache_wd = {1'b1, pick};
      cache_ra = key;
      err_we   = 1'b0;
      err_wa   = {sel_ff, x_ff};
      err_wd   = '0;
      err_ra   = {sel_ff, col_ff};

      unique case (state_ff)
         // sweep cache and error rows
         S_CLR: begin
            cache_wa = clr_ff[pfsd_pkg::CACHE_AW-1:0];
            cache_wd = '0;
            cache_we = ((clr_ff >> pfsd_pkg::CACHE_AW) == '0);
            err_wa   = clr_ff[pfsd_pkg::ERR_AW-1:0];
            err_we   = ((clr_ff >> pfsd_pkg::ERR_AW) == '0);
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_data.req_type)
                  pfsd_pkg::REQ_LOAD: begin
                     pal_we = 1'b1;
                  end
                  pfsd_pkg::REQ_PIXEL: begin
                     x_in     = col_ff;
                     lcol_in  = ((13'(col_ff) + 13'd1) >= w_eff);
                     lrow_in  = ((17'(row_ff) + 17'd1) >= h_eff);
                     pin_in   = {req_data.blue, req_data.green, req_data.red};
                     state_in = S_SUM;
                  end
                  pfsd_pkg::REQ_START: begin
                     clr_in   = '0;
                     col_in   = '0;
                     row_in   = '0;
                     sel_in   = 1'b0;
                     right_in = '0;
                     state_in = S_CLR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // add diffused error, clamp, clear the consumed entry
         S_SUM: begin
            for (int c = 0; c < NCH; c++) begin
               logic signed [V_W-1:0] v;
               v = $signed(V_W'({pin_ff[c], 4'b0000}))
                 + V_W'($signed(err_rd_ff[c])) + V_W'($signed(right_ff[c]));
               if (v[V_W-1]) begin
                  val_in[c] = 8'd0;
               end else if (v[V_W-2:12] != '0) begin
                  val_in[c] = 8'd255;
               end else begin
                  val_in[c] = v[11:4];
               end
            end
            err_we   = 1'b1;
            state_in = S_CRD;
         end
         S_CRD: begin
            state_in = S_CCHK;
         end
         S_CCHK: begin
            if (cache_rd_ff[PAL_AW]) begin
               ent_in   = cache_rd_ff[PAL_AW-1:0];
               state_in = S_PAL;
            end else begin
               idx_in   = '0;
               state_in = S_PRD;
            end
         end
         // nearest-entry walk, one squarer step per cycle
         S_PRD: begin
            state_in = S_D0;
         end
         S_D0: begin
            acc_in   = '0;
            state_in = S_D1;
         end
         S_D1: begin
            acc_in   = acc_ff + wsq;
            state_in = S_D2;
         end
         S_D2: begin
            acc_in   = acc_ff + wsq;
            state_in = S_D3;
         end
         S_D3: begin
            acc_in   = acc_ff + wsq;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (better) begin
               best_in  = idx_ff;
               bestd_in = acc_ff;
            end
            if (hit_zero || last_idx) begin
               cache_we = 1'b1;
               ent_in   = pick;
               state_in = S_PAL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_PRD;
            end
         end
         S_PAL: begin
            state_in = S_ERR;
         end
         // quantization error and rightward share
         S_ERR: begin
            for (int c = 0; c < NCH; c++) begin
               dq_in[c]    = D_W'({2'b00, val_ff[c]}) - D_W'({2'b00, pal_rd_ff.color[c]});
               right_in[c] = lcol_ff ? '0 : ERR_W'($signed(dq_in[c])) * ERR_W'(7);
            end
            code_in = pal_rd_ff.code;
            tgt_in  = (x_ff != '0) ? T_LEFT : T_CENTER;
            state_in = lrow_ff ? S_EMIT : S_DRD;
         end
         // read-modify-write of the next row
         S_DRD: begin
            err_ra   = {!sel_ff, tgt_x};
            state_in = S_DWR;
         end
         S_DWR: begin
            err_we = 1'b1;
            err_wa = {!sel_ff, tgt_x};
            for (int c = 0; c < NCH; c++) begin
               logic [ERR_W-1:0] k;
               unique case (tgt_ff)
                  T_LEFT:  k = ERR_W'(3);
                  T_RIGHT: k = ERR_W'(1);
                  default: k = ERR_W'(5);
               endcase
               err_wd[c] = err_rd_ff[c] + ERR_W'($signed(dq_ff[c])) * k;
            end
            priority case (tgt_ff)
               T_LEFT: begin
                  tgt_in   = T_CENTER;
                  state_in = S_DRD;
               end
               T_CENTER: begin
                  tgt_in   = T_RIGHT;
                  state_in = right_ok ? S_DRD : S_EMIT;
               end
               default: begin
                  state_in = S_EMIT;
               end
            endcase
         end
         // hand result to the output register, advance position
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_pixel = code_ff;
               rsp_data_in.row_end   = lcol_ff;
               rsp_data_in.image_end = lcol_ff && lrow_ff;
               if (lcol_ff) begin
                  col_in = '0;
                  sel_in = !sel_ff;
                  row_in = lrow_ff ? 16'd0 : row_ff + 16'd1;
               end else begin
                  col_in = x_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         width_ff     <= 13'd640;
         height_ff    <= 16'd480;
         psize_ff     <= 9'd256;
         col_ff       <= '0;
         row_ff       <= '0;
         sel_ff       <= 1'b0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         sel_ff       <= sel_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               pfsd_pkg::CSR_LINE_WIDTH:   width_ff  <= csr_data[12:0];
               pfsd_pkg::CSR_LINE_COUNT:   height_ff <= csr_data;
               pfsd_pkg::CSR_PALETTE_SIZE: psize_ff  <= csr_data[8:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      lcol_ff     <= lcol_in;
      lrow_ff     <= lrow_in;
      pin_ff      <= pin_in;
      val_ff      <= val_in;
      dq_ff       <= dq_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      bestd_ff    <= bestd_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      ent_ff      <= ent_in;
      code_ff     <= code_in;
      tgt_ff      <= tgt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // palette memory
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_wa] <= {req_data.entry_code, req_data.blue, req_data.green,
                             req_data.red};
      end
      pal_rd_ff <= pal_mem[pal_ra];
   end

   // color cache memory
   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[cache_wa] <= cache_wd;
      end
      cache_rd_ff <= cache_mem[cache_ra];
   end

   // error row memory, two rows ping-pong
   always_ff @(posedge clock) begin
      if (err_we) begin
         err_mem[err_wa] <= err_wd;
      end
      err_rd_ff <= err_mem[err_ra];
   end

endmodule

### rtl/pfsd_checker.sv
// ----------------------------------------------------------------------------
// pfsd_assert_checker
// Port-level checks of the dither core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfsd_assert_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input pfsd_pkg::pfsd_req_type           req_data,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input pfsd_pkg::pfsd_rsp_type           rsp_data,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [pfsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [pfsd_pkg::CSR_DATA_W-1:0]  csr_data
);

   // a stalled beat stays offered
   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped")

   // a stalled beat keeps its payload
   `ASSERT_CLK(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp beat changed")

   // image end only on a row end
   `ASSERT_CLK(a_end_nest, rsp_valid |-> (!rsp_data.image_end || rsp_data.row_end), "bad end")

   // pixel work holds req_ready low in the cycle after its acceptance
   `ASSERT_CLK(a_pixel_busy, req_valid && req_ready && req_data.req_type == 2'd1 |=> !req_ready, "busy")

   // clearing pass follows reset
   `ASSERT_ALWAYS(a_reset_clear, reset |=> !req_ready, "ready right after reset")

endmodule

bind palette_floyd_steinberg_dither_core pfsd_assert_checker u_pfsd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index),
   .csr_data  (csr_data)
);
